FILE: rtl/ncau_pkg.sv
// Shared types and constants for the nearest-centroid accumulate block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ncau_pkg;

    localparam int SLOT_W    = 4;
    localparam int NEAREST_W = 4;
    localparam int DIST_W    = 25;
    localparam int SUM_W     = 48;
    localparam int HIT_W     = 32;
    localparam int CNT_W     = 5;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd8;

    typedef enum logic [0:0] {
        OP_LOAD     = 1'b0,
        OP_CLASSIFY = 1'b1
    } t_ncau_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } t_ncau_state;

    // control bits that travel with a point along the cell row
    typedef struct packed {
        logic valid;
        logic best_ok;
        logic pend_ok;
    } t_ncau_flags;

    // one accumulator entry
    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [HIT_W-1:0] hits;
    } t_ncau_sums;

endpackage

`default_nettype wire

FILE: rtl/ncau_in_if.sv
// Input channel of the nearest-centroid block: valid/ready plus one item.
// Depends on ncau_pkg for the fixed field widths.
`default_nettype none

interface ncau_in_if #(
    parameter int COORD_BITS = 12
);
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [ncau_pkg::SLOT_W-1:0]    slot;
    logic [COORD_BITS-1:0]          coord_x;
    logic [COORD_BITS-1:0]          coord_y;

    modport source (output valid, operation, slot, coord_x, coord_y, input ready);
    modport sink   (input valid, operation, slot, coord_x, coord_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/ncau_out_if.sv
// Result channel of the nearest-centroid block: valid/ready plus one item.
// Depends on ncau_pkg for the field widths.
`default_nettype none

interface ncau_out_if;
    logic                           valid;
    logic                           ready;
    logic [ncau_pkg::NEAREST_W-1:0] nearest;
    logic [ncau_pkg::DIST_W-1:0]    best_distance;
    logic [ncau_pkg::SUM_W-1:0]     total_x;
    logic [ncau_pkg::SUM_W-1:0]     total_y;
    logic [ncau_pkg::HIT_W-1:0]     assigned_count;

    modport source (output valid, nearest, best_distance, total_x, total_y,
                    assigned_count, input ready);
    modport sink   (input valid, nearest, best_distance, total_x, total_y,
                    assigned_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/ncau_cell.sv
// One cell of the centroid row: holds a centroid, computes its squared
// distance to the passing point and folds the previous cell's candidate in.
// Depends on ncau_pkg (t_ncau_flags).
`default_nettype none

module ncau_cell #(
    parameter int CELL_IDX      = 0,
    parameter int MAX_CENTROIDS = 16,
    parameter int COORD_BITS    = 12
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_load,
    input  wire  [COORD_BITS-1:0]                i_load_x,
    input  wire  [COORD_BITS-1:0]                i_load_y,
    input  wire                                  i_active,
    input  ncau_pkg::t_ncau_flags                i_flags,
    input  wire  [COORD_BITS-1:0]                i_px,
    input  wire  [COORD_BITS-1:0]                i_py,
    input  wire  [$clog2(MAX_CENTROIDS)-1:0]     i_best_idx,
    input  wire  [2*COORD_BITS:0]                i_best_dist,
    input  wire  [$clog2(MAX_CENTROIDS)-1:0]     i_pend_idx,
    input  wire  [2*COORD_BITS:0]                i_pend_dist,
    output ncau_pkg::t_ncau_flags                o_flags,
    output logic [COORD_BITS-1:0]                o_px,
    output logic [COORD_BITS-1:0]                o_py,
    output logic [$clog2(MAX_CENTROIDS)-1:0]     o_best_idx,
    output logic [2*COORD_BITS:0]                o_best_dist,
    output logic [$clog2(MAX_CENTROIDS)-1:0]     o_pend_idx,
    output logic [2*COORD_BITS:0]                o_pend_dist
);
    localparam int IW = $clog2(MAX_CENTROIDS);
    localparam int CW = COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 1;

    logic [CW-1:0]   r_cx;
    logic [CW-1:0]   r_cy;
    logic [CW-1:0]   w_dx;
    logic [CW-1:0]   w_dy;
    logic [2*CW-1:0] w_sqx;
    logic [2*CW-1:0] w_sqy;
    logic [DW-1:0]   w_dist;
    logic            w_take;

    ncau_pkg::t_ncau_flags r_flags;
    logic [CW-1:0]         r_px;
    logic [CW-1:0]         r_py;
    logic [IW-1:0]         r_best_idx;
    logic [DW-1:0]         r_best_dist;
    logic [IW-1:0]         r_pend_idx;
    logic [DW-1:0]         r_pend_dist;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cx <= i_load_x;
            r_cy <= i_load_y;
        end
    end

    always_comb begin
        w_dx   = (i_px >= r_cx) ? (i_px - r_cx) : (r_cx - i_px);
        w_dy   = (i_py >= r_cy) ? (i_py - r_cy) : (r_cy - i_py);
        w_sqx  = (2*CW)'(w_dx) * (2*CW)'(w_dx);
        w_sqy  = (2*CW)'(w_dy) * (2*CW)'(w_dy);
        w_dist = DW'(w_sqx) + DW'(w_sqy);
        // strict less-than: a tie keeps the earlier, lower-index best
        w_take = i_flags.pend_ok && (!i_flags.best_ok || (i_pend_dist < i_best_dist));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags.valid   <= i_flags.valid;
            r_flags.best_ok <= i_flags.best_ok | i_flags.pend_ok;
            r_flags.pend_ok <= i_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px        <= i_px;
        r_py        <= i_py;
        r_best_idx  <= w_take ? i_pend_idx  : i_best_idx;
        r_best_dist <= w_take ? i_pend_dist : i_best_dist;
        r_pend_idx  <= IW'(CELL_IDX);
        r_pend_dist <= w_dist;
    end

    assign o_flags     = r_flags;
    assign o_px        = r_px;
    assign o_py        = r_py;
    assign o_best_idx  = r_best_idx;
    assign o_best_dist = r_best_dist;
    assign o_pend_idx  = r_pend_idx;
    assign o_pend_dist = r_pend_dist;

endmodule

`default_nettype wire

FILE: rtl/nearest_centroid_accumulate_unit.sv
// Nearest-centroid search with per-centroid accumulation (k-means assignment).
// Depends on ncau_pkg, ncau_in_if, ncau_out_if and ncau_cell.
//
// Usage:
//   i_item carries load items (operation 0: store centroid coord_x/coord_y
//   at slot and clear its sums) and classify items (operation 1: a point).
//   o_result returns one item per classify: nearest index, squared
//   distance and the updated x sum, y sum and hit count of that centroid.
//   i_cfg_wr_en/i_cfg_wr_data write centroid_count; write it only when idle.
// Timing:
//   A load leaves the block idle, so the next item may follow at once.
//   A classify walks the row of MAX_CENTROIDS cells, one cell per cycle,
//   then reads the winner's accumulator entry into a register and
//   rewrites it as the result is registered; no new item is taken until
//   that commit returns the block to idle.
// Reset: centroid_count returns to 8 and all sums and counts read as zero;
//   centroid coordinates are undefined until loaded.
// Stall: a finished result waits in the output register; a new item is
//   still taken, and a classify holds before its commit until that result
//   is taken.
`default_nettype none

module nearest_centroid_accumulate_unit #(
    parameter int MAX_CENTROIDS = 16,
    parameter int COORD_BITS    = 12
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire  [ncau_pkg::CNT_W-1:0]       i_cfg_wr_data,
    ncau_in_if.sink                          i_item,
    ncau_out_if.source                       o_result
);
    localparam int IW    = $clog2(MAX_CENTROIDS);
    localparam int CW    = COORD_BITS;
    localparam int DW    = 2 * COORD_BITS + 1;
    localparam int CNTW  = $clog2(MAX_CENTROIDS + 1);
    localparam int NW    = (CNTW > ncau_pkg::CNT_W) ? CNTW : ncau_pkg::CNT_W;

    // configuration
    logic [ncau_pkg::CNT_W-1:0] r_count;
    logic [NW-1:0]              w_cnt_ext;
    logic [NW-1:0]              w_n;
    logic [MAX_CENTROIDS-1:0]   w_active;

    // control
    ncau_pkg::t_ncau_state r_state;
    ncau_pkg::t_ncau_state n_state;
    logic                  w_accept;
    logic                  w_is_load;
    logic                  w_is_classify;
    logic                  w_slot_ok;
    logic [IW-1:0]         w_slot_idx;
    logic                  w_inject;
    logic                  w_capture;
    logic                  w_commit;

    // cell row links
    ncau_pkg::t_ncau_flags w_flags     [MAX_CENTROIDS+1];
    logic [CW-1:0]         w_px        [MAX_CENTROIDS+1];
    logic [CW-1:0]         w_py        [MAX_CENTROIDS+1];
    logic [IW-1:0]         w_best_idx  [MAX_CENTROIDS+1];
    logic [DW-1:0]         w_best_dist [MAX_CENTROIDS+1];
    logic [IW-1:0]         w_pend_idx  [MAX_CENTROIDS+1];
    logic [DW-1:0]         w_pend_dist [MAX_CENTROIDS+1];

    // final compare after the last cell
    logic          w_last_take;
    logic [IW-1:0] w_fin_idx;
    logic [DW-1:0] w_fin_dist;
    logic [IW-1:0] r_best_idx;
    logic [DW-1:0] r_best_dist;
    logic [CW-1:0] r_px;
    logic [CW-1:0] r_py;

    // accumulator memory
    ncau_pkg::t_ncau_sums r_mem [MAX_CENTROIDS];
    logic [MAX_CENTROIDS-1:0] r_sum_ok;
    ncau_pkg::t_ncau_sums r_rd_data;
    logic                 r_rd_ok;
    ncau_pkg::t_ncau_sums w_old;
    ncau_pkg::t_ncau_sums w_new;
    logic                 w_wr_en;
    logic [IW-1:0]        w_wr_addr;
    ncau_pkg::t_ncau_sums w_wr_data;

    // output register
    logic                           r_out_valid;
    logic [ncau_pkg::NEAREST_W-1:0] r_out_nearest;
    logic [ncau_pkg::DIST_W-1:0]    r_out_dist;
    logic [ncau_pkg::SUM_W-1:0]     r_out_x;
    logic [ncau_pkg::SUM_W-1:0]     r_out_y;
    logic [ncau_pkg::HIT_W-1:0]     r_out_hits;
    logic                           w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ncau_pkg::CNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_count <= i_cfg_wr_data;
        end
    end

    // count of zero searches one centroid; above the row length saturates
    always_comb begin
        w_cnt_ext = NW'(r_count);
        if (w_cnt_ext == '0) begin
            w_n = NW'(1);
        end else if (w_cnt_ext > NW'(MAX_CENTROIDS)) begin
            w_n = NW'(MAX_CENTROIDS);
        end else begin
            w_n = w_cnt_ext;
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_CENTROIDS; k++) begin
            w_active[k] = NW'(k) < w_n;
        end
    end

    assign i_item.ready  = (r_state == ncau_pkg::ST_IDLE);
    assign w_accept      = i_item.valid && i_item.ready;
    assign w_is_load     = w_accept && (i_item.operation == ncau_pkg::OP_LOAD);
    assign w_is_classify = w_accept && (i_item.operation == ncau_pkg::OP_CLASSIFY);
    assign w_slot_ok     = 32'(i_item.slot) < 32'(MAX_CENTROIDS);
    assign w_slot_idx    = IW'(i_item.slot);
    assign w_inject      = w_is_classify;
    assign w_out_free    = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_capture = 1'b0;
        w_commit  = 1'b0;
        unique case (r_state)
            ncau_pkg::ST_IDLE: begin
                if (w_is_classify) begin
                    n_state = ncau_pkg::ST_SEARCH;
                end
            end
            ncau_pkg::ST_SEARCH: begin
                if (w_flags[MAX_CENTROIDS].valid) begin
                    w_capture = 1'b1;
                    n_state   = ncau_pkg::ST_UPDATE;
                end
            end
            ncau_pkg::ST_UPDATE: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = ncau_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ncau_pkg::ST_IDLE;
            end
        endcase
    end

    // head of the row: a fresh point with no candidates yet
    assign w_flags[0]     = '{valid: w_inject, best_ok: 1'b0, pend_ok: 1'b0};
    assign w_px[0]        = i_item.coord_x;
    assign w_py[0]        = i_item.coord_y;
    assign w_best_idx[0]  = '0;
    assign w_best_dist[0] = '0;
    assign w_pend_idx[0]  = '0;
    assign w_pend_dist[0] = '0;

    for (genvar g = 0; g < MAX_CENTROIDS; g++) begin : g_cell
        ncau_cell #(
            .CELL_IDX      (g),
            .MAX_CENTROIDS (MAX_CENTROIDS),
            .COORD_BITS    (COORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_is_load && w_slot_ok && (w_slot_idx == IW'(g))),
            .i_load_x    (i_item.coord_x),
            .i_load_y    (i_item.coord_y),
            .i_active    (w_active[g]),
            .i_flags     (w_flags[g]),
            .i_px        (w_px[g]),
            .i_py        (w_py[g]),
            .i_best_idx  (w_best_idx[g]),
            .i_best_dist (w_best_dist[g]),
            .i_pend_idx  (w_pend_idx[g]),
            .i_pend_dist (w_pend_dist[g]),
            .o_flags     (w_flags[g+1]),
            .o_px        (w_px[g+1]),
            .o_py        (w_py[g+1]),
            .o_best_idx  (w_best_idx[g+1]),
            .o_best_dist (w_best_dist[g+1]),
            .o_pend_idx  (w_pend_idx[g+1]),
            .o_pend_dist (w_pend_dist[g+1])
        );
    end

    // the last cell's own distance is still pending at the end of the row
    always_comb begin
        w_last_take = w_flags[MAX_CENTROIDS].pend_ok &&
                      (!w_flags[MAX_CENTROIDS].best_ok ||
                       (w_pend_dist[MAX_CENTROIDS] < w_best_dist[MAX_CENTROIDS]));
        w_fin_idx   = w_last_take ? w_pend_idx[MAX_CENTROIDS]  : w_best_idx[MAX_CENTROIDS];
        w_fin_dist  = w_last_take ? w_pend_dist[MAX_CENTROIDS] : w_best_dist[MAX_CENTROIDS];
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_best_idx  <= w_fin_idx;
            r_best_dist <= w_fin_dist;
            r_px        <= w_px[MAX_CENTROIDS];
            r_py        <= w_py[MAX_CENTROIDS];
        end
    end

    // accumulator read-modify-write; unwritten entries read as zero
    always_comb begin
        w_old       = r_rd_ok ? r_rd_data : '0;
        w_new.sum_x = w_old.sum_x + ncau_pkg::SUM_W'(r_px);
        w_new.sum_y = w_old.sum_y + ncau_pkg::SUM_W'(r_py);
        w_new.hits  = w_old.hits + ncau_pkg::HIT_W'(1);
        w_wr_en     = w_commit || (w_is_load && w_slot_ok);
        w_wr_addr   = w_commit ? r_best_idx : w_slot_idx;
        w_wr_data   = w_commit ? w_new : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_capture) begin
            r_rd_data <= r_mem[w_fin_idx];
            r_rd_ok   <= r_sum_ok[w_fin_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_ok <= '0;
        end else if (w_wr_en) begin
            r_sum_ok[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_nearest <= ncau_pkg::NEAREST_W'(r_best_idx);
            r_out_dist    <= ncau_pkg::DIST_W'(r_best_dist);
            r_out_x       <= w_new.sum_x;
            r_out_y       <= w_new.sum_y;
            r_out_hits    <= w_new.hits;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.nearest        = r_out_nearest;
    assign o_result.best_distance  = r_out_dist;
    assign o_result.total_x        = r_out_x;
    assign o_result.total_y        = r_out_y;
    assign o_result.assigned_count = r_out_hits;

endmodule

`default_nettype wire
